// ----- src/gbnms_pkg.sv -----
// Shared types and constants for the greedy box suppression block.
// No dependencies; the top module, the compare unit and the testbench import it.
package gbnms_pkg;

  localparam int COORD_W = 16;
  localparam int LABEL_W = 10;
  localparam int AREA_W  = 32;
  localparam int THR_W   = 9;
  localparam int IDX_W   = 13;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_IOU_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CLASS_AGNOSTIC = 1'b1;

  localparam logic [THR_W-1:0] THR_RESET = 9'd115;

  typedef struct packed {
    logic signed [COORD_W-1:0] left_edge;
    logic signed [COORD_W-1:0] top_edge;
    logic signed [COORD_W-1:0] right_edge;
    logic signed [COORD_W-1:0] bottom_edge;
    logic [LABEL_W-1:0]        class_label;
    logic                      final_box;
  } in_item_t;

  typedef struct packed {
    logic             kept;
    logic [IDX_W-1:0] box_index;
    logic             store_full;
    logic             frame_done;
  } out_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] bottom;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] left;
  } box_t;

  typedef struct packed {
    logic [AREA_W-1:0]  area;
    logic [LABEL_W-1:0] label;
    box_t               box;
  } entry_t;

  typedef struct packed {
    logic [THR_W-1:0] thr;
    logic             agnostic;
  } cmp_cfg_t;

  typedef struct packed {
    logic hit_v;
    logic hit;
    logic busy;
  } cmp_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

// ----- src/greedy_box_nms.sv -----
// Greedy box suppression: each item is checked against the kept-box store.
// From accept, the scan reads one stored box per cycle, then the four compare
// stages drain and the result is registered. One item is taken at a time; a
// waiting result holds the block in its final step and stalls the input.
// Reset (synchronous, rst_n low) empties the store and restores the settings.
module greedy_box_nms #(
  parameter int MAX_KEPT  = 256,
  parameter int MAX_BOXES = 8192
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gbnms_pkg::in_item_t   in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output gbnms_pkg::out_item_t  out_item,
  input  logic                  cfg_we,
  input  logic [0:0]            cfg_index,
  input  logic [8:0]            cfg_wdata
);
  import gbnms_pkg::*;

  localparam int AW = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CW = $clog2(MAX_KEPT + 1);
  localparam int PW = $clog2(MAX_BOXES);
  localparam int EW = $bits(entry_t);

  state_t               state_r, state_nxt;
  box_t                 box_r, box_nxt;
  logic [LABEL_W-1:0]   label_r, label_nxt;
  logic                 final_r, final_nxt;
  logic [AREA_W-1:0]    area_r;
  logic [THR_W-1:0]     thr_r;
  logic                 agn_r;
  logic [CW-1:0]        kept_cnt_r, kept_cnt_nxt;
  logic [CW-1:0]        ptr_r, ptr_nxt;
  logic [PW-1:0]        pos_r, pos_nxt;
  logic                 rd_vld_r;
  logic                 supp_r, supp_nxt;
  logic                 out_valid_r, out_valid_nxt;
  out_item_t            out_item_r, out_item_nxt;

  logic                 rd_en, mem_we, busy_all, fin_fire, store_full, sat, keep;
  logic [COORD_W-1:0]   dx, dy;
  logic [EW-1:0]        rd_data;
  entry_t               wr_ent;
  cmp_cfg_t             cmp_cfg;
  cmp_res_t             cmp_res;

  gbnms_ram #(
    .DEPTH (MAX_KEPT),
    .AW    (AW),
    .WIDTH (EW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (kept_cnt_r[AW-1:0]),
    .wdata (wr_ent),
    .re    (rd_en),
    .raddr (ptr_r[AW-1:0]),
    .rdata (rd_data)
  );

  assign cmp_cfg.thr      = thr_r;
  assign cmp_cfg.agnostic = agn_r;

  gbnms_cmp u_cmp (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cmp_cfg),
    .box   (box_r),
    .label (label_r),
    .area  (area_r),
    .ent_v (rd_vld_r),
    .ent   (entry_t'(rd_data)),
    .res   (cmp_res)
  );

  assign dx = COORD_W'(box_r.right - box_r.left);
  assign dy = COORD_W'(box_r.bottom - box_r.top);

  assign wr_ent.area  = area_r;
  assign wr_ent.label = label_r;
  assign wr_ent.box   = box_r;

  assign busy_all   = rd_vld_r || cmp_res.busy;
  assign keep       = !supp_r;
  assign store_full = keep && (kept_cnt_r == CW'(MAX_KEPT));
  assign sat        = (pos_r == PW'(MAX_BOXES - 1));

  always_comb begin
    state_nxt     = state_r;
    box_nxt       = box_r;
    label_nxt     = label_r;
    final_nxt     = final_r;
    kept_cnt_nxt  = kept_cnt_r;
    ptr_nxt       = ptr_r;
    pos_nxt       = pos_r;
    supp_nxt      = supp_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_item_nxt  = out_item_r;
    in_ready      = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    fin_fire      = 1'b0;
    if (cmp_res.hit_v && cmp_res.hit) begin
      supp_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          box_nxt.left   = in_item.left_edge;
          box_nxt.top    = in_item.top_edge;
          box_nxt.right  = (in_item.right_edge < in_item.left_edge) ?
                           in_item.left_edge : in_item.right_edge;
          box_nxt.bottom = (in_item.bottom_edge < in_item.top_edge) ?
                           in_item.top_edge : in_item.bottom_edge;
          label_nxt = in_item.class_label;
          final_nxt = in_item.final_box;
          ptr_nxt   = '0;
          supp_nxt  = 1'b0;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (ptr_r == kept_cnt_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rd_en   = 1'b1;
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      ST_DRAIN: begin
        if (!busy_all) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || out_ready) begin
          fin_fire                = 1'b1;
          mem_we                  = keep && !store_full;
          out_valid_nxt           = 1'b1;
          out_item_nxt.kept       = keep;
          out_item_nxt.box_index  = IDX_W'(pos_r);
          out_item_nxt.store_full = store_full || sat;
          out_item_nxt.frame_done = final_r;
          if (final_r) begin
            kept_cnt_nxt = '0;
            pos_nxt      = '0;
          end else begin
            kept_cnt_nxt = kept_cnt_r + CW'(mem_we);
            pos_nxt      = sat ? pos_r : pos_r + PW'(1);
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      kept_cnt_r  <= '0;
      pos_r       <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
      thr_r       <= THR_RESET;
      agn_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      kept_cnt_r  <= kept_cnt_nxt;
      pos_r       <= pos_nxt;
      rd_vld_r    <= rd_en;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IOU_THRESHOLD:  thr_r <= cfg_wdata[THR_W-1:0];
          REG_CLASS_AGNOSTIC: agn_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    box_r      <= box_nxt;
    label_r    <= label_nxt;
    final_r    <= final_nxt;
    ptr_r      <= ptr_nxt;
    supp_r     <= supp_nxt;
    out_item_r <= out_item_nxt;
    area_r     <= AREA_W'(dx) * AREA_W'(dy);
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    kept_cnt_r <= CW'(MAX_KEPT))
    else $error("kept count beyond store depth");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !busy_all)
    else $error("compare pipeline busy while taking an item");

  a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && final_r) |=> (kept_cnt_r == '0) && (pos_r == '0))
    else $error("store not cleared after final item");

  a_write_finish: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_FINISH) && !busy_all)
    else $error("store written during scan");

endmodule

// ----- src/gbnms_ram.sv -----
// Single-port-write, single-port-read store of kept boxes, registered read.
// Generic; no package dependencies.
module gbnms_ram #(
  parameter int DEPTH = 256,
  parameter int AW    = 8,
  parameter int WIDTH = 106
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/gbnms_cmp.sv -----
// Four-stage overlap test of the current box against one stored entry.
// Depends on gbnms_pkg.
module gbnms_cmp (
  input  logic                clk,
  input  logic                rst_n,
  input  gbnms_pkg::cmp_cfg_t cfg,
  input  gbnms_pkg::box_t     box,
  input  logic [9:0]          label,
  input  logic [31:0]         area,
  input  logic                ent_v,
  input  gbnms_pkg::entry_t   ent,
  output gbnms_pkg::cmp_res_t res
);
  import gbnms_pkg::*;

  logic                 v0_r, v1_r, v2_r, v3_r;
  logic                 m0_r, m1_r, m2_r;
  logic signed [16:0]   w0_r, h0_r;
  logic [AREA_W-1:0]    ka0_r, ka1_r;
  logic [AREA_W-1:0]    inter1_r, inter2_r;
  logic [AREA_W:0]      uni2_r;
  logic                 hit3_r;

  logic signed [COORD_W-1:0] mn_r, mx_l, mn_b, mx_t;
  logic signed [16:0]        w0_nxt, h0_nxt;
  logic                      m0_nxt;
  logic [AREA_W-1:0]         inter1_nxt;
  logic [AREA_W:0]           uni2_nxt;
  logic [41:0]               prod, lhs;

  always_comb begin
    mn_r = (box.right < ent.box.right) ? box.right : ent.box.right;
    mx_l = (box.left > ent.box.left) ? box.left : ent.box.left;
    mn_b = (box.bottom < ent.box.bottom) ? box.bottom : ent.box.bottom;
    mx_t = (box.top > ent.box.top) ? box.top : ent.box.top;
    w0_nxt = $signed({mn_r[15], mn_r}) - $signed({mx_l[15], mx_l});
    h0_nxt = $signed({mn_b[15], mn_b}) - $signed({mx_t[15], mx_t});
    m0_nxt = cfg.agnostic || (ent.label == label);
  end

  always_comb begin
    if (w0_r[16] || (w0_r == 17'sd0) || h0_r[16] || (h0_r == 17'sd0)) begin
      inter1_nxt = '0;
    end else begin
      inter1_nxt = AREA_W'(w0_r[15:0]) * AREA_W'(h0_r[15:0]);
    end
    uni2_nxt = {1'b0, area} + {1'b0, ka1_r} - {1'b0, inter1_r};
    prod = 42'(cfg.thr) * 42'(uni2_r);
    lhs  = {2'b00, inter2_r, 8'h00};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v0_r <= ent_v;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    w0_r     <= w0_nxt;
    h0_r     <= h0_nxt;
    m0_r     <= m0_nxt;
    ka0_r    <= ent.area;
    inter1_r <= inter1_nxt;
    ka1_r    <= ka0_r;
    m1_r     <= m0_r;
    uni2_r   <= uni2_nxt;
    inter2_r <= inter1_r;
    m2_r     <= m1_r;
    hit3_r   <= m2_r && (lhs > prod);
  end

  assign res.hit_v = v3_r;
  assign res.hit   = hit3_r;
  assign res.busy  = v0_r || v1_r || v2_r || v3_r;

endmodule

// ----- sim/greedy_box_nms_tb.sv -----
`timescale 1ns / 100ps
// Testbench for greedy_box_nms: streams detection boxes, predicts every
// keep/suppress verdict from its own copy of the kept-box store and checks each result.
// Depends on gbnms_pkg and the greedy_box_nms RTL.
module greedy_box_nms_tb;
  import gbnms_pkg::*;

  localparam int KEPT_DEPTH   = 256;
  localparam int STREAM_DEPTH = 8192;
  localparam int HOLD_CYCLES  = 1500;
  localparam int TILE_PITCH   = 3200;
  localparam int TILE_SIZE    = 1600;

  logic                 clk;
  logic                 rst_n     = 1'b0;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_item   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_item;
  logic                 cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  in_item_t         box_queue[$];
  out_item_t        pending_verdicts[$];
  entry_t           kept_store[KEPT_DEPTH];
  int               kept_total       = 0;
  int               next_index       = 0;
  logic [THR_W-1:0] thr_setting      = THR_RESET;
  logic             agnostic_setting = 1'b0;
  int               send_idle_pct    = 6;
  int               recv_idle_pct    = 51;
  int               hold_requests    = 0;
  int               holds_served     = 0;
  int               hold_left        = 0;
  int               mismatches       = 0;

  greedy_box_nms #(
    .MAX_KEPT (KEPT_DEPTH),
    .MAX_BOXES(STREAM_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic out_item_t nms_decide(in_item_t it);
    int                l, t, r, b, kl, kt, kr, kb, w, h, idx;
    logic [AREA_W-1:0] area;
    longint unsigned   inter, uni;
    logic              keep, full;
    out_item_t         verdict;
    l = $signed(it.left_edge);
    t = $signed(it.top_edge);
    r = $signed(it.right_edge);
    b = $signed(it.bottom_edge);
    if (r < l) r = l;
    if (b < t) b = t;
    area = (r - l) * (b - t);
    keep = 1'b1;
    full = 1'b0;
    for (int i = 0; i < kept_total; i++) begin
      if (!agnostic_setting && kept_store[i].label != it.class_label) continue;
      kl = $signed(kept_store[i].box.left);
      kt = $signed(kept_store[i].box.top);
      kr = $signed(kept_store[i].box.right);
      kb = $signed(kept_store[i].box.bottom);
      w = ((r < kr) ? r : kr) - ((l > kl) ? l : kl);
      h = ((b < kb) ? b : kb) - ((t > kt) ? t : kt);
      inter = (w > 0 && h > 0) ? longint'(w) * longint'(h) : 64'd0;
      uni = area;
      uni = uni + kept_store[i].area - inter;
      if ((inter << 8) > uni * thr_setting) keep = 1'b0;
    end
    if (keep) begin
      if (kept_total < KEPT_DEPTH) begin
        kept_store[kept_total].box.left   = l[COORD_W-1:0];
        kept_store[kept_total].box.top    = t[COORD_W-1:0];
        kept_store[kept_total].box.right  = r[COORD_W-1:0];
        kept_store[kept_total].box.bottom = b[COORD_W-1:0];
        kept_store[kept_total].label      = it.class_label;
        kept_store[kept_total].area       = area;
        kept_total++;
      end else begin
        full = 1'b1;
      end
    end
    idx = next_index;
    if (idx >= STREAM_DEPTH - 1) begin
      idx  = STREAM_DEPTH - 1;
      full = 1'b1;
    end else begin
      next_index = idx + 1;
    end
    verdict.kept       = keep;
    verdict.box_index  = idx[IDX_W-1:0];
    verdict.store_full = full;
    verdict.frame_done = it.final_box;
    if (it.final_box) begin
      kept_total = 0;
      next_index = 0;
    end
    return verdict;
  endfunction

  task automatic check_verdict(out_item_t got);
    out_item_t want;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: unexpected result item, expected none, actual %h", $time, got);
      mismatches++;
    end else begin
      want = pending_verdicts.pop_front();
      if (got.kept !== want.kept) begin
        $display("%0t: kept expected %0d actual %0d", $time, want.kept, got.kept);
        mismatches++;
      end
      if (got.box_index !== want.box_index) begin
        $display("%0t: box_index expected %0d actual %0d", $time, want.box_index,
                 got.box_index);
        mismatches++;
      end
      if (got.store_full !== want.store_full) begin
        $display("%0t: store_full expected %0d actual %0d", $time, want.store_full,
                 got.store_full);
        mismatches++;
      end
      if (got.frame_done !== want.frame_done) begin
        $display("%0t: frame_done expected %0d actual %0d", $time, want.frame_done,
                 got.frame_done);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) pending_verdicts = {pending_verdicts, nms_decide(in_item)};
      if (box_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_item  <= box_queue.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_verdict(out_item);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  task automatic queue_box(int l, int t, int r, int b, int label, bit last);
    in_item_t it;
    it.left_edge   = l[COORD_W-1:0];
    it.top_edge    = t[COORD_W-1:0];
    it.right_edge  = r[COORD_W-1:0];
    it.bottom_edge = b[COORD_W-1:0];
    it.class_label = label[LABEL_W-1:0];
    it.final_box   = last;
    box_queue = {box_queue, it};
  endtask

  task automatic wait_drained();
    while (box_queue.size() != 0 || in_valid || pending_verdicts.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    wait_drained();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CFG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_IOU_THRESHOLD) thr_setting = value[THR_W-1:0];
    else agnostic_setting = value[0];
  endtask

  function automatic int jitter(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // Clustered boxes overlap often enough to exercise suppression on both sides.
  task automatic queue_random_frame(int len);
    int cx[4], cy[4], cs[4], cl[4];
    int clusters, k, sel, l, t, r, b, label, span;
    clusters = $urandom_range(1, 4);
    for (int c = 0; c < 4; c++) begin
      cx[c] = int'($urandom_range(0, 40000)) - 20000;
      cy[c] = int'($urandom_range(0, 40000)) - 20000;
      cs[c] = $urandom_range(16, 1600);
      cl[c] = $urandom_range(0, 3);
    end
    for (int n = 0; n < len; n++) begin
      k     = $urandom_range(0, clusters - 1);
      span  = cs[k] / 4;
      l     = cx[k] + jitter(span);
      t     = cy[k] + jitter(span);
      r     = l + cs[k] + jitter(span);
      b     = t + cs[k] + jitter(span);
      label = cl[k];
      sel   = $urandom_range(0, 99);
      if (sel < 8) begin
        l     = $urandom;
        t     = $urandom;
        r     = $urandom;
        b     = $urandom;
        label = $urandom_range(0, 1023);
      end else if (sel < 16) begin
        r = l - int'($urandom_range(0, 400));
      end else if (sel < 22) begin
        b = t - int'($urandom_range(0, 400));
      end else if (sel < 30) begin
        label = $urandom_range(0, 1023);
      end
      queue_box(l, t, r, b, label, n == len - 1);
    end
  endtask

  task automatic queue_random_phase(int count);
    int queued, len;
    queued = 0;
    while (queued < count) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 24);
      queue_random_frame(len);
      queued += len;
    end
  endtask

  initial begin
    #240_000_000;
    $display("greedy_box_nms verification failed");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: threshold 115, per-class comparison
    queue_box(0, 0, 160, 160, 5, 0);
    queue_box(0, 0, 160, 160, 5, 0);
    queue_box(0, 0, 160, 160, 6, 0);
    queue_box(120, 0, 280, 160, 5, 0);
    queue_box(8, 8, 168, 168, 5, 0);
    queue_box(1000, 0, 900, 100, 5, 0);
    queue_box(1000, 0, 900, 100, 5, 0);
    queue_box(2000, 500, 2100, 400, 5, 0);
    queue_box(-32768, -32768, 32767, 32767, 1023, 0);
    queue_box(-32768, -32768, 32767, 32767, 1023, 0);
    queue_box(32767, 32767, -32768, -32768, 0, 1);
    queue_box(0, 0, 160, 160, 5, 1);

    write_reg(REG_IOU_THRESHOLD, 0);
    queue_box(0, 0, 160, 160, 3, 0);
    queue_box(150, 150, 310, 310, 3, 0);
    queue_box(1000, 1000, 1100, 1100, 3, 1);

    write_reg(REG_IOU_THRESHOLD, 256);
    queue_box(0, 0, 160, 160, 2, 0);
    queue_box(0, 0, 160, 160, 2, 0);
    queue_box(0, 0, 160, 160, 2, 1);

    write_reg(REG_IOU_THRESHOLD, 115);
    write_reg(REG_CLASS_AGNOSTIC, 1);
    queue_box(0, 0, 160, 160, 5, 0);
    queue_box(0, 0, 160, 160, 9, 0);
    queue_box(5000, 5000, 5100, 5100, 1, 1);

    // fill the store past capacity with disjoint tiles
    wait_drained();
    for (int row = 0; row < 16; row++) begin
      for (int col = 0; col < 17; col++) begin
        queue_box(-27000 + col * TILE_PITCH, -27000 + row * TILE_PITCH,
                  -27000 + col * TILE_PITCH + TILE_SIZE,
                  -27000 + row * TILE_PITCH + TILE_SIZE, $urandom_range(0, 1023), 0);
      end
    end
    queue_box(-27000, -27000, -27000 + TILE_SIZE, -27000 + TILE_SIZE, 0, 0);
    queue_box(-27000 + 5 * TILE_PITCH, -27000 + 15 * TILE_PITCH,
              -27000 + 5 * TILE_PITCH + TILE_SIZE, -27000 + 15 * TILE_PITCH + TILE_SIZE, 0, 0);
    queue_box(-27000 + 5 * TILE_PITCH, -27000 + 15 * TILE_PITCH,
              -27000 + 5 * TILE_PITCH + TILE_SIZE, -27000 + 15 * TILE_PITCH + TILE_SIZE, 0, 1);

    write_reg(REG_CLASS_AGNOSTIC, 0);
    wait_drained();
    hold_requests++;
    queue_random_phase(260);

    wait_drained();
    send_idle_pct = 51;
    recv_idle_pct = 6;
    write_reg(REG_IOU_THRESHOLD, $urandom_range(0, 256));
    write_reg(REG_CLASS_AGNOSTIC, 1);
    queue_random_phase(260);

    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(REG_IOU_THRESHOLD, 230);
    write_reg(REG_CLASS_AGNOSTIC, 0);
    queue_random_phase(260);

    wait_drained();
    repeat (KEPT_DEPTH + 16) @(posedge clk);
    if (mismatches == 0)
      $display("greedy_box_nms verification clean");
    else
      $display("greedy_box_nms verification failed");
    $finish;
  end

endmodule

// ----- sim.f -----
src/gbnms_pkg.sv
src/gbnms_ram.sv
src/gbnms_cmp.sv
src/greedy_box_nms.sv
sim/greedy_box_nms_tb.sv
